// ----- hdl/msl_pkg.sv -----
// Shared constants, types and reset helpers for the multi-axis slew limiter.
// No dependencies; imported by msl_slew_lane and multi_axis_slew_limiter_unit.
`default_nettype none

package msl_pkg;

    localparam int AXIS_SLOTS      = 8;
    localparam int AXIS_W          = 16;
    localparam int BUTTON_W        = 11;
    localparam int RATE_W          = 16;
    localparam int DT_W            = 20;
    localparam int LEVEL_W         = 2;
    localparam int STEP_W          = 16;
    localparam int RATE_SHIFT      = 20;
    localparam int CFG_IDX_W       = 2;

    localparam int NUM_AXES_DEF    = 8;
    localparam int NUM_BUTTONS_DEF = 11;

    localparam int BTN_DOWN        = 4;
    localparam int BTN_UP          = 5;

    localparam logic [STEP_W-1:0] STEP_CAP = STEP_W'(32768);

    localparam logic FUNC_MSG  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic [LEVEL_W-1:0] LVL_SLOW = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_MID  = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_FAST = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_RATE_SLOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_MID  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_FAST = 2'd2;

    // 0.5, 1.5 and 3.0 full scale per second
    localparam logic [RATE_W-1:0] RATE_SLOW_RST = 16'd8590;
    localparam logic [RATE_W-1:0] RATE_MID_RST  = 16'd25770;
    localparam logic [RATE_W-1:0] RATE_FAST_RST = 16'd51540;

    typedef logic signed [AXIS_W-1:0] axis_t;
    typedef logic [STEP_W-1:0]        step_t;

    // Axes 2 and 5 rest at full scale, the others at center.
    function automatic axis_t axis_reset(input int idx);
        axis_t v;
        v = '0;
        if (idx == 2 || idx == 5)
        begin
            v = AXIS_W'(16384);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/msl_slew_lane.sv -----
// One axis lane: moves a held value toward its goal by at most one step.
// Depends on msl_pkg.
`default_nettype none

module msl_slew_lane
(
    input  wire msl_pkg::axis_t held,
    input  wire msl_pkg::axis_t goal,
    input  wire msl_pkg::step_t step,
    output msl_pkg::axis_t      nxt
);
    import msl_pkg::*;

    logic signed [AXIS_W:0] held_x;
    logic signed [AXIS_W:0] diff;
    logic        [AXIS_W:0] err;
    logic        [AXIS_W:0] step_x;
    logic signed [AXIS_W:0] moved;
    logic                   near;

    always_comb
    begin
        held_x = {held[AXIS_W-1], held};
        diff   = {goal[AXIS_W-1], goal} - held_x;
        err    = diff[AXIS_W] ? (AXIS_W+1)'(-diff) : diff;
        step_x = (AXIS_W+1)'(step);
        near   = err < step_x;
        // held + step never passes the goal here, so the result stays in range
        moved  = diff[AXIS_W] ? (held_x - $signed(step_x)) : (held_x + $signed(step_x));
        nxt    = near ? goal : moved[AXIS_W-1:0];
    end

endmodule

`default_nettype wire

// ----- hdl/multi_axis_slew_limiter_unit.sv -----
// Top level of the multi-axis slew limiter: input register, step multiply and
// rate-level logic, slew lanes, result register. Depends on msl_pkg, msl_slew_lane.
//
//  channel | signals                                  | role
//  --------+------------------------------------------+------------------------------
//  in      | in_valid in_ready func target_a0..7      | message or tick item
//          | button_bits elapsed_us                   |
//  out     | out_valid out_ready out_a0..7            | one result item per input item
//          | out_buttons changed rate_level           |
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data   | rate register writes
//
// One item per cycle sustained while the output is not stalled; an accepted item
// reaches out_valid through the input register, step register and result register.
// The stage after the input register does the rate multiply and level update, the
// next one the NUM_AXES slew lanes. A stalled output holds all three stages in place;
// in_ready stays high as long as some stage can move. Reset returns rates, goal, held
// output, level (fast) and arming to their power-up values; cfg_ready is always high.
`default_nettype none

module multi_axis_slew_limiter_unit
#(
    parameter int NUM_AXES    = msl_pkg::NUM_AXES_DEF,
    parameter int NUM_BUTTONS = msl_pkg::NUM_BUTTONS_DEF
)
(
    input  wire                            clk,
    input  wire                            rst_n,

    input  wire                            in_valid,
    output logic                           in_ready,
    input  wire                            func,
    input  wire msl_pkg::axis_t            target_a0,
    input  wire msl_pkg::axis_t            target_a1,
    input  wire msl_pkg::axis_t            target_a2,
    input  wire msl_pkg::axis_t            target_a3,
    input  wire msl_pkg::axis_t            target_a4,
    input  wire msl_pkg::axis_t            target_a5,
    input  wire msl_pkg::axis_t            target_a6,
    input  wire msl_pkg::axis_t            target_a7,
    input  wire [msl_pkg::BUTTON_W-1:0]    button_bits,
    input  wire [msl_pkg::DT_W-1:0]        elapsed_us,

    output logic                           out_valid,
    input  wire                            out_ready,
    output msl_pkg::axis_t                 out_a0,
    output msl_pkg::axis_t                 out_a1,
    output msl_pkg::axis_t                 out_a2,
    output msl_pkg::axis_t                 out_a3,
    output msl_pkg::axis_t                 out_a4,
    output msl_pkg::axis_t                 out_a5,
    output msl_pkg::axis_t                 out_a6,
    output msl_pkg::axis_t                 out_a7,
    output logic [msl_pkg::BUTTON_W-1:0]   out_buttons,
    output logic                           changed,
    output logic [msl_pkg::LEVEL_W-1:0]    rate_level,

    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire [msl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire [msl_pkg::RATE_W-1:0]      cfg_data
);
    import msl_pkg::*;

    localparam int BtnW  = (NUM_BUTTONS < BUTTON_W) ? NUM_BUTTONS : BUTTON_W;
    localparam int ProdW = RATE_W + DT_W;

    // configuration
    logic [RATE_W-1:0] rate_slow_reg, rate_mid_reg, rate_fast_reg;

    // stage 1: input register
    logic              s1_vld_reg;
    logic              s1_func_reg;
    axis_t             s1_tgt_reg [NUM_AXES];
    logic [BtnW-1:0]   s1_btn_reg;
    logic [DT_W-1:0]   s1_dt_reg;

    // stage 2: step and level
    logic              s2_vld_reg;
    logic              s2_func_reg;
    axis_t             s2_tgt_reg [NUM_AXES];
    logic [BtnW-1:0]   s2_btn_reg;
    step_t             s2_step_reg;
    logic [LEVEL_W-1:0] s2_lvl_reg;

    // block state
    logic [LEVEL_W-1:0] lvl_reg, lvl_next;
    logic               armed_reg, armed_next;
    axis_t              goal_reg [NUM_AXES];
    axis_t              held_reg [NUM_AXES];
    logic [BtnW-1:0]    goal_btn_reg;
    logic [BtnW-1:0]    held_btn_reg;

    // result register
    logic               vo_reg;
    axis_t              o_ax_reg [NUM_AXES];
    logic [BtnW-1:0]    o_btn_reg;
    logic               o_chg_reg;
    logic [LEVEL_W-1:0] o_lvl_reg;

    logic adv_o, adv_2, take_in;

    axis_t             tgt_in [AXIS_SLOTS];
    axis_t             slewed [NUM_AXES];
    axis_t             held_next [NUM_AXES];
    axis_t             out_all [AXIS_SLOTS];
    logic [RATE_W-1:0] rate_sel;
    logic [ProdW-1:0]  prod;
    step_t             step_raw;
    step_t             step_sat;
    logic              btn_down, btn_up;
    logic              differ;

    assign tgt_in[0] = target_a0;
    assign tgt_in[1] = target_a1;
    assign tgt_in[2] = target_a2;
    assign tgt_in[3] = target_a3;
    assign tgt_in[4] = target_a4;
    assign tgt_in[5] = target_a5;
    assign tgt_in[6] = target_a6;
    assign tgt_in[7] = target_a7;

    // pipeline flow
    assign adv_o     = s2_vld_reg && (!vo_reg || out_ready);
    assign adv_2     = s1_vld_reg && (!s2_vld_reg || adv_o);
    assign in_ready  = !s1_vld_reg || adv_2;
    assign take_in   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_slow_reg <= RATE_SLOW_RST;
            rate_mid_reg  <= RATE_MID_RST;
            rate_fast_reg <= RATE_FAST_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RATE_SLOW: rate_slow_reg <= cfg_data;
                CFG_RATE_MID:  rate_mid_reg  <= cfg_data;
                CFG_RATE_FAST: rate_fast_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // stage 1 capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            s1_func_reg <= func;
            s1_btn_reg  <= button_bits[BtnW-1:0];
            s1_dt_reg   <= elapsed_us;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                s1_tgt_reg[i] <= tgt_in[i];
            end
        end
    end

    // stage 1 -> 2: rate multiply and rate-level buttons
    always_comb
    begin
        case (lvl_reg)
            LVL_SLOW: rate_sel = rate_slow_reg;
            LVL_MID:  rate_sel = rate_mid_reg;
            default:  rate_sel = rate_fast_reg;
        endcase
        prod     = ProdW'(rate_sel) * ProdW'(s1_dt_reg);
        step_raw = prod[ProdW-1:RATE_SHIFT];
        step_sat = (step_raw > STEP_CAP) ? STEP_CAP : step_raw;

        btn_down   = s1_btn_reg[BTN_DOWN];
        btn_up     = s1_btn_reg[BTN_UP];
        lvl_next   = lvl_reg;
        armed_next = armed_reg;
        if (s1_func_reg == FUNC_MSG)
        begin
            if (armed_reg)
            begin
                if (btn_down)
                begin
                    lvl_next   = (lvl_reg == LVL_SLOW) ? LVL_FAST : LEVEL_W'(lvl_reg - 2'd1);
                    armed_next = 1'b0;
                end
                else if (btn_up)
                begin
                    lvl_next   = (lvl_reg >= LVL_FAST) ? LVL_SLOW : LEVEL_W'(lvl_reg + 2'd1);
                    armed_next = 1'b0;
                end
            end
            // re-arm once both rate buttons are released
            if (!armed_next && !btn_down && !btn_up)
            begin
                armed_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
            lvl_reg    <= LVL_FAST;
            armed_reg  <= 1'b1;
        end
        else
        begin
            if (!s2_vld_reg || adv_o)
            begin
                s2_vld_reg <= s1_vld_reg;
            end
            if (adv_2)
            begin
                lvl_reg   <= lvl_next;
                armed_reg <= armed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_2)
        begin
            s2_func_reg <= s1_func_reg;
            s2_btn_reg  <= s1_btn_reg;
            s2_step_reg <= step_sat;
            s2_lvl_reg  <= lvl_next;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                s2_tgt_reg[i] <= s1_tgt_reg[i];
            end
        end
    end

    // stage 2 -> result: slew lanes
    genvar g;
    generate
        for (g = 0; g < NUM_AXES; g++)
        begin : g_lane
            msl_slew_lane u_lane
            (
                .held (held_reg[g]),
                .goal (goal_reg[g]),
                .step (s2_step_reg),
                .nxt  (slewed[g])
            );
        end
    endgenerate

    always_comb
    begin
        differ = (goal_btn_reg != held_btn_reg);
        for (int i = 0; i < NUM_AXES; i++)
        begin
            if (goal_reg[i] != held_reg[i])
            begin
                differ = 1'b1;
            end
        end
        for (int i = 0; i < NUM_AXES; i++)
        begin
            held_next[i] = (s2_func_reg == FUNC_TICK && differ) ? slewed[i] : held_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg       <= 1'b0;
            goal_btn_reg <= '0;
            held_btn_reg <= '0;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                goal_reg[i] <= axis_reset(i);
                held_reg[i] <= axis_reset(i);
            end
        end
        else
        begin
            if (!vo_reg || out_ready)
            begin
                vo_reg <= s2_vld_reg;
            end
            if (adv_o)
            begin
                if (s2_func_reg == FUNC_MSG)
                begin
                    goal_btn_reg <= s2_btn_reg;
                    for (int i = 0; i < NUM_AXES; i++)
                    begin
                        goal_reg[i] <= s2_tgt_reg[i];
                    end
                end
                else if (differ)
                begin
                    held_btn_reg <= goal_btn_reg;
                    for (int i = 0; i < NUM_AXES; i++)
                    begin
                        held_reg[i] <= held_next[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_o)
        begin
            o_btn_reg <= (s2_func_reg == FUNC_TICK && differ) ? goal_btn_reg : held_btn_reg;
            o_chg_reg <= (s2_func_reg == FUNC_TICK) && differ;
            o_lvl_reg <= s2_lvl_reg;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                o_ax_reg[i] <= held_next[i];
            end
        end
    end

    // unused axis slots read as zero
    generate
        for (g = 0; g < AXIS_SLOTS; g++)
        begin : g_out
            if (g < NUM_AXES)
            begin : g_used
                assign out_all[g] = o_ax_reg[g];
            end
            else
            begin : g_unused
                assign out_all[g] = '0;
            end
        end
    endgenerate

    assign out_valid   = vo_reg;
    assign out_a0      = out_all[0];
    assign out_a1      = out_all[1];
    assign out_a2      = out_all[2];
    assign out_a3      = out_all[3];
    assign out_a4      = out_all[4];
    assign out_a5      = out_all[5];
    assign out_a6      = out_all[6];
    assign out_a7      = out_all[7];
    assign out_buttons = BUTTON_W'(o_btn_reg);
    assign changed     = o_chg_reg;
    assign rate_level  = o_lvl_reg;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for multi_axis_slew_limiter_unit: directed and random
// message and tick items checked against an in-bench predictor of the slew logic.
// Depends on msl_pkg and the unit RTL only.
module tb;
    import msl_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_SLACK = 12;
    localparam int AXIS_FULL   = 16384;
    localparam int EXP_DEPTH   = 64;

    // index past the three rate registers; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam logic [BUTTON_W-1:0] BTN_DOWN_MASK = BUTTON_W'(1 << BTN_DOWN);
    localparam logic [BUTTON_W-1:0] BTN_UP_MASK   = BUTTON_W'(1 << BTN_UP);
    localparam logic [BUTTON_W-1:0] BTN_ALL       = '1;
    localparam logic [DT_W-1:0]     DT_MAX        = '1;

    typedef struct packed {
        logic                              func;
        logic [AXIS_SLOTS-1:0][AXIS_W-1:0] target;
        logic [BUTTON_W-1:0]               buttons;
        logic [DT_W-1:0]                   elapsed;
    } joy_item_t;

    typedef struct packed {
        logic [AXIS_SLOTS-1:0][AXIS_W-1:0] axes;
        logic [BUTTON_W-1:0]               buttons;
        logic                              changed;
        logic [LEVEL_W-1:0]                level;
    } joy_out_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                              in_valid    = 1'b0;
    logic                              func        = FUNC_MSG;
    logic [AXIS_SLOTS-1:0][AXIS_W-1:0] tgt_bus     = '0;
    logic [BUTTON_W-1:0]               button_bits = '0;
    logic [DT_W-1:0]                   elapsed_us  = '0;
    logic                              out_ready   = 1'b0;
    logic                              cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]              cfg_index   = '0;
    logic [RATE_W-1:0]                 cfg_data    = '0;

    wire                              in_ready;
    wire                              out_valid;
    wire                              cfg_ready;
    wire [AXIS_SLOTS-1:0][AXIS_W-1:0] out_bus;
    wire [BUTTON_W-1:0]               out_buttons;
    wire                              changed;
    wire [LEVEL_W-1:0]                rate_level;

    // predictor state
    int                  held_pos [AXIS_SLOTS];
    int                  goal_pos [AXIS_SLOTS];
    logic [BUTTON_W-1:0] held_btn;
    logic [BUTTON_W-1:0] goal_btn;
    logic [LEVEL_W-1:0]  level_sel;
    logic                level_armed;
    logic [RATE_W-1:0]   rate_slow_r;
    logic [RATE_W-1:0]   rate_mid_r;
    logic [RATE_W-1:0]   rate_fast_r;

    // expected outputs in order, written by the sender and read by the checker
    joy_out_t exp_ring [EXP_DEPTH];
    int       exp_wr = 0;
    int       exp_rd = 0;

    int     mismatch_count = 0;
    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    int     hold_req       = 0;
    int     hold_seen      = 0;
    int     hold_left      = 0;
    longint cycle_count    = 0;

    multi_axis_slew_limiter_unit dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .target_a0   (tgt_bus[0]),
        .target_a1   (tgt_bus[1]),
        .target_a2   (tgt_bus[2]),
        .target_a3   (tgt_bus[3]),
        .target_a4   (tgt_bus[4]),
        .target_a5   (tgt_bus[5]),
        .target_a6   (tgt_bus[6]),
        .target_a7   (tgt_bus[7]),
        .button_bits (button_bits),
        .elapsed_us  (elapsed_us),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_a0      (out_bus[0]),
        .out_a1      (out_bus[1]),
        .out_a2      (out_bus[2]),
        .out_a3      (out_bus[3]),
        .out_a4      (out_bus[4]),
        .out_a5      (out_bus[5]),
        .out_a6      (out_bus[6]),
        .out_a7      (out_bus[7]),
        .out_buttons (out_buttons),
        .changed     (changed),
        .rate_level  (rate_level),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic reset_predictor();
        int i;
        for (i = 0; i < AXIS_SLOTS; i++)
        begin
            held_pos[i] = (i == 2 || i == 5) ? AXIS_FULL : 0;
            goal_pos[i] = held_pos[i];
        end
        held_btn    = '0;
        goal_btn    = '0;
        level_sel   = LVL_FAST;
        level_armed = 1'b1;
        rate_slow_r = RATE_SLOW_RST;
        rate_mid_r  = RATE_MID_RST;
        rate_fast_r = RATE_FAST_RST;
    endtask

    // Advance the predictor by one item and queue the output it must produce.
    task automatic predict_output(input joy_item_t itm);
        joy_out_t          r;
        logic              down;
        logic              up;
        logic              differ;
        logic [RATE_W-1:0] rate;
        longint            step;
        int                err;
        int                i;
        r.changed = 1'b0;
        if (itm.func == FUNC_MSG)
        begin
            for (i = 0; i < AXIS_SLOTS; i++)
            begin
                goal_pos[i] = $signed(itm.target[i]);
            end
            goal_btn = itm.buttons;
            down     = goal_btn[BTN_DOWN];
            up       = goal_btn[BTN_UP];
            if (level_armed)
            begin
                if (down)
                begin
                    level_sel   = (level_sel == LVL_SLOW) ? LVL_FAST : level_sel - 1'b1;
                    level_armed = 1'b0;
                end
                else if (up)
                begin
                    level_sel   = (level_sel >= LVL_FAST) ? LVL_SLOW : level_sel + 1'b1;
                    level_armed = 1'b0;
                end
            end
            if (!level_armed && !down && !up)
            begin
                level_armed = 1'b1;
            end
        end
        else
        begin
            differ = (goal_btn != held_btn);
            for (i = 0; i < AXIS_SLOTS; i++)
            begin
                if (goal_pos[i] != held_pos[i])
                begin
                    differ = 1'b1;
                end
            end
            if (differ)
            begin
                case (level_sel)
                    LVL_SLOW: rate = rate_slow_r;
                    LVL_MID:  rate = rate_mid_r;
                    default:  rate = rate_fast_r;
                endcase
                step = (longint'(rate) * longint'(itm.elapsed)) >> RATE_SHIFT;
                if (step > longint'(STEP_CAP))
                begin
                    step = longint'(STEP_CAP);
                end
                for (i = 0; i < AXIS_SLOTS; i++)
                begin
                    if (goal_pos[i] != held_pos[i])
                    begin
                        err = (goal_pos[i] > held_pos[i]) ? goal_pos[i] - held_pos[i]
                                                          : held_pos[i] - goal_pos[i];
                        if (err < step)
                        begin
                            held_pos[i] = goal_pos[i];
                        end
                        else if (goal_pos[i] > held_pos[i])
                        begin
                            held_pos[i] = held_pos[i] + int'(step);
                        end
                        else
                        begin
                            held_pos[i] = held_pos[i] - int'(step);
                        end
                    end
                end
                held_btn  = goal_btn;
                r.changed = 1'b1;
            end
        end
        for (i = 0; i < AXIS_SLOTS; i++)
        begin
            r.axes[i] = AXIS_W'(held_pos[i]);
        end
        r.buttons = held_btn;
        r.level   = level_sel;
        exp_ring[exp_wr % EXP_DEPTH] = r;
        exp_wr++;
    endtask

    // Offer one item after a random gap and hold it until accepted.
    task automatic send_item(input joy_item_t itm);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        func        <= itm.func;
        tgt_bus     <= itm.target;
        button_bits <= itm.buttons;
        elapsed_us  <= itm.elapsed;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        predict_output(itm);
    endtask

    // Drop valid and wait until every queued output has come back.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (exp_wr != exp_rd)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_rates(input logic [RATE_W-1:0] slow, input logic [RATE_W-1:0] mid,
                             input logic [RATE_W-1:0] fast, input logic [RATE_W-1:0] spare);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [RATE_W-1:0]    val [4];
        int                   k;
        idx = '{CFG_RATE_SLOW, CFG_RATE_MID, CFG_RATE_FAST, CFG_SPARE};
        val = '{slow, mid, fast, spare};
        for (k = 0; k < 4; k++)
        begin
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            cfg_valid <= 1'b1;
            @(posedge clk);
            while (!cfg_ready)
            begin
                @(posedge clk);
            end
            case (idx[k])
                CFG_RATE_SLOW: rate_slow_r = val[k];
                CFG_RATE_MID:  rate_mid_r  = val[k];
                CFG_RATE_FAST: rate_fast_r = val[k];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic joy_item_t msg_item(input logic [AXIS_W-1:0] v,
                                           input logic [BUTTON_W-1:0] b);
        joy_item_t itm;
        int        i;
        itm      = '0;
        itm.func = FUNC_MSG;
        for (i = 0; i < AXIS_SLOTS; i++)
        begin
            itm.target[i] = v;
        end
        itm.buttons = b;
        return itm;
    endfunction

    function automatic joy_item_t tick_item(input logic [DT_W-1:0] dt);
        joy_item_t itm;
        itm         = '0;
        itm.func    = FUNC_TICK;
        itm.elapsed = dt;
        return itm;
    endfunction

    function automatic joy_item_t rand_item(input logic fn);
        joy_item_t itm;
        int        i;
        int        pick;
        itm.func = fn;
        for (i = 0; i < AXIS_SLOTS; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                itm.target[i] = AXIS_W'($urandom_range(0, 2 * AXIS_FULL) - AXIS_FULL);
            end
            else if (pick < 9)
            begin
                itm.target[i] = (pick == 7) ? AXIS_W'(AXIS_FULL) : AXIS_W'(-AXIS_FULL);
            end
            else
            begin
                itm.target[i] = AXIS_W'($urandom);
            end
        end
        itm.buttons = BUTTON_W'($urandom);
        // release the rate buttons half the time so the level logic re-arms
        if ($urandom_range(0, 1) == 0)
        begin
            itm.buttons = itm.buttons & ~(BTN_DOWN_MASK | BTN_UP_MASK);
        end
        pick = $urandom_range(0, 9);
        if (pick < 6)
        begin
            itm.elapsed = DT_W'($urandom_range(0, 60000));
        end
        else if (pick < 9)
        begin
            itm.elapsed = DT_W'($urandom);
        end
        else
        begin
            itm.elapsed = (pick[0]) ? DT_MAX : '0;
        end
        return itm;
    endfunction

    task automatic run_random_phase(input int n_items, input int idle_pct, input int stall_pct);
        int sent;
        int ticks;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent           = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                // message followed by a run of ticks that walk the axes toward it
                send_item(rand_item(FUNC_MSG));
                sent++;
                ticks = $urandom_range(1, 6);
                repeat (ticks)
                begin
                    send_item(rand_item(FUNC_TICK));
                    sent++;
                end
            end
            else
            begin
                send_item(rand_item(1'($urandom_range(0, 1))));
                sent++;
            end
        end
        settle();
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_reset_state();
        joy_item_t itm;
        send_item(tick_item(DT_MAX));
        itm           = msg_item('0, '0);
        itm.target[2] = AXIS_W'(AXIS_FULL);
        itm.target[5] = AXIS_W'(AXIS_FULL);
        send_item(itm);
        send_item(tick_item(DT_MAX));
        settle();
    endtask

    task automatic test_field_extremes();
        send_item(msg_item(AXIS_W'(AXIS_FULL), BTN_ALL & ~(BTN_DOWN_MASK | BTN_UP_MASK)));
        send_item(tick_item('0));
        send_item(tick_item(DT_MAX));
        send_item(tick_item(DT_MAX));
        send_item(msg_item(AXIS_W'(-AXIS_FULL), '0));
        send_item(tick_item(DT_MAX));
        // beyond the nominal range: full positive then full negative code
        send_item(msg_item(16'h7FFF, '0));
        send_item(tick_item(DT_MAX));
        send_item(tick_item(DT_MAX));
        send_item(msg_item(16'h8000, '0));
        send_item(tick_item(DT_MAX));
        send_item(tick_item(DT_MAX));
        settle();
    endtask

    task automatic test_rate_buttons();
        send_item(msg_item('0, BTN_DOWN_MASK));
        send_item(msg_item('0, BTN_DOWN_MASK));
        send_item(msg_item('0, '0));
        send_item(msg_item('0, BTN_UP_MASK));
        send_item(msg_item('0, '0));
        send_item(msg_item('0, BTN_UP_MASK));
        send_item(msg_item('0, '0));
        send_item(msg_item('0, BTN_DOWN_MASK));
        send_item(msg_item('0, '0));
        send_item(msg_item('0, BTN_DOWN_MASK | BTN_UP_MASK));
        send_item(msg_item('0, '0));
        settle();
    endtask

    task automatic test_ignored_fields();
        joy_item_t itm;
        itm         = rand_item(FUNC_MSG);
        itm.elapsed = DT_MAX;
        send_item(itm);
        itm         = rand_item(FUNC_TICK);
        itm.buttons = BTN_ALL;
        send_item(itm);
        settle();
    endtask

    task automatic test_rate_registers();
        set_rates('0, '0, '0, '1);
        run_random_phase(30, 0, 0);
        set_rates('1, '1, '1, '0);
        run_random_phase(30, 0, 0);
        set_rates(16'd1, 16'h8000, '1, RATE_W'($urandom));
        run_random_phase(30, 0, 0);
        set_rates(RATE_W'($urandom), RATE_W'($urandom), RATE_W'($urandom), RATE_W'($urandom));
        run_random_phase(30, 0, 0);
        set_rates(RATE_SLOW_RST, RATE_MID_RST, RATE_FAST_RST, RATE_W'($urandom));
        run_random_phase(30, 0, 0);
    endtask

    task automatic test_random_traffic();
        run_random_phase(200, 0, 0);
        set_rates(RATE_W'($urandom), RATE_W'($urandom), RATE_W'($urandom), RATE_W'($urandom));
        run_random_phase(200, 86, 0);
        set_rates(RATE_W'($urandom_range(0, 4000)), RATE_W'($urandom), '1, '0);
        run_random_phase(200, 0, 86);
        set_rates(RATE_SLOW_RST, RATE_MID_RST, RATE_FAST_RST, '1);
        run_random_phase(200, 18, 18);
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req++;
        repeat (40)
        begin
            send_item(rand_item(1'($urandom_range(0, 1))));
        end
        settle();
        run_random_phase(20, 0, 0);
    endtask

    // ---------------------------------------------------------------- receiver

    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_outputs
        joy_out_t want;
        int       i;
        if (rst_n && out_valid && out_ready)
        begin
            if (exp_wr == exp_rd)
            begin
                $error("output item with nothing expected");
                mismatch_count++;
            end
            else
            begin
                want = exp_ring[exp_rd % EXP_DEPTH];
                exp_rd++;
                for (i = 0; i < AXIS_SLOTS; i++)
                begin
                    if (out_bus[i] !== want.axes[i])
                    begin
                        $error("out_a%0d expected %0d got %0d", i,
                               $signed(want.axes[i]), $signed(out_bus[i]));
                        mismatch_count++;
                    end
                end
                if (out_buttons !== want.buttons)
                begin
                    $error("out_buttons expected %h got %h", want.buttons, out_buttons);
                    mismatch_count++;
                end
                if (changed !== want.changed)
                begin
                    $error("changed expected %0d got %0d", want.changed, changed);
                    mismatch_count++;
                end
                if (rate_level !== want.level)
                begin
                    $error("rate_level expected %0d got %0d", want.level, rate_level);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        reset_predictor();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_field_extremes();
        test_rate_buttons();
        test_ignored_fields();
        test_rate_registers();
        test_random_traffic();
        test_backpressure();
        settle();
        repeat (DRAIN_SLACK) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
